### design/slp_pkg.sv
`default_nettype none

package slp_pkg;

  typedef enum logic [2:0] {
    PH_REBOOT  = 3'd0,
    PH_READY   = 3'd1,
    PH_VERSION = 3'd2,
    PH_PARAMS  = 3'd3,
    PH_SCAN    = 3'd4
  } phase_t;

  localparam logic [2:0] REQ_ALIVE   = 3'd0;
  localparam logic [2:0] REQ_VERSION = 3'd1;
  localparam logic [2:0] REQ_DATA    = 3'd2;
  localparam logic [2:0] REQ_OTHER   = 3'd3;
  localparam logic [2:0] REQ_TIMEOUT = 3'd4;
  localparam logic [2:0] REQ_INVALID = 3'd5;

  localparam int unsigned MF_CENTRED   = 0;
  localparam int unsigned MF_MOTOR_ON  = 1;
  localparam int unsigned MF_MOTORING  = 2;
  localparam int unsigned MF_NO_PARAMS = 3;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_SEL_RETRY  = 1'b0;
  localparam logic REG_SEL_WINDOW = 1'b1;

  localparam logic [7:0] RETRY_PERIOD_RST = 8'd10;
  localparam logic [3:0] REQ_WINDOW_RST   = 4'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic       flag_centred;
    logic       flag_motor_on;
    logic       flag_motoring;
    logic       flag_no_params;
    logic       queue_full;
  } in_word_t;

  typedef struct packed {
    logic       send_reboot;
    logic       send_version_request;
    logic       send_params;
    logic       push_data;
    logic       drop_data;
    logic [3:0] data_requests;
    logic       reset_link;
    logic [2:0] phase;
  } out_word_t;

endpackage

`default_nettype wire

### design/slp_if.sv
`default_nettype none

interface slp_in_if;
  import slp_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface slp_out_if;
  import slp_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/sonar_link_protocol_fsm.sv
// Sonar head link protocol controller.
// in_ch carries one link event word per handshake (type, head status flags,
// buffer-full flag); out_ch carries one action word per event: packets to
// send, keep or drop head data, data requests to issue and the new phase.
// Every accepted event yields exactly one action word, in order.
// The action word is registered and valid the cycle after the event is accepted.
// Throughput: one event per cycle while out_ch is not stalled. The phase,
// credit, retry and flag registers update at the accepting edge, and the
// action word lands in a single output register.
// When out_ch stalls, the output register holds its word and in_ch.ready
// drops until that word is taken; taking it and accepting a new event can
// happen in the same cycle.
// The APB-style port writes version_retry_period at 0x0 and request_window
// at 0x4; write only while no event is in flight.
// Synchronous reset (rst_n low) returns to the reboot phase with zero credit,
// zero retry count, head not alive, cleared motor flags, default
// registers (period 10, window 3) and an empty output register.
`default_nettype none

module sonar_link_protocol_fsm
  import slp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  slp_in_if.sink                     in_ch,
  slp_out_if.source                  out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  logic [7:0] retry_period_r;
  logic [3:0] req_window_r;

  phase_t     phase_r, phase_nxt;
  logic [3:0] credit_r, credit_nxt;
  logic [7:0] retry_r, retry_nxt;
  logic       alive_r, alive_nxt;
  logic [3:0] flags_r, flags_nxt;

  logic       out_valid_r;
  out_word_t  out_r, out_nxt;

  logic       in_acc;
  logic       cfg_wr;
  logic [7:0] period_eff;
  logic [8:0] retry_inc;
  logic [3:0] credit_dec;
  in_word_t   iw;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_SEL_RETRY:  prdata = {24'd0, retry_period_r};
      REG_SEL_WINDOW: prdata = {28'd0, req_window_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_period_r <= RETRY_PERIOD_RST;
      req_window_r   <= REQ_WINDOW_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SEL_RETRY) begin
        retry_period_r <= pwdata[7:0];
      end else begin
        req_window_r <= pwdata[3:0];
      end
    end
  end

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign iw           = in_ch.data;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  assign period_eff = (retry_period_r == 8'd0) ? 8'd1 : retry_period_r;
  assign retry_inc  = {1'b0, retry_r} + 9'd1;

  always_comb begin
    phase_nxt  = phase_r;
    credit_nxt = credit_r;
    retry_nxt  = retry_r;
    alive_nxt  = alive_r;
    flags_nxt  = flags_r;
    credit_dec = credit_r;

    if (iw.req_type == REQ_TIMEOUT) begin
      if (alive_r) begin
        phase_nxt  = PH_REBOOT;
        credit_nxt = 4'd0;
        alive_nxt  = 1'b0;
      end
    end else if (iw.req_type <= REQ_OTHER) begin
      if (iw.req_type == REQ_ALIVE) begin
        alive_nxt = 1'b1;
        flags_nxt = {iw.flag_no_params, iw.flag_motoring, iw.flag_motor_on, iw.flag_centred};
      end
      case (phase_r)
        PH_REBOOT: begin
          flags_nxt[MF_CENTRED] = 1'b0;
          phase_nxt             = PH_READY;
        end
        PH_READY: begin
          if (flags_nxt[MF_CENTRED] && flags_nxt[MF_MOTOR_ON] && !flags_nxt[MF_MOTORING]) begin
            phase_nxt = PH_VERSION;
          end
        end
        PH_VERSION: begin
          if (iw.req_type == REQ_VERSION) begin
            phase_nxt = PH_PARAMS;
          end else begin
            retry_nxt = (retry_inc >= {1'b0, period_eff}) ? 8'd0 : retry_inc[7:0];
          end
        end
        PH_PARAMS: begin
          if (!flags_nxt[MF_NO_PARAMS]) begin
            phase_nxt = PH_SCAN;
          end
        end
        PH_SCAN: begin
          if (iw.req_type == REQ_DATA && credit_r != 4'd0) begin
            credit_dec = credit_r - 4'd1;
          end
          credit_nxt = credit_dec;
          if (req_window_r > credit_dec) begin
            credit_nxt = req_window_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_nxt = '0;

    if (iw.req_type == REQ_TIMEOUT) begin
      out_nxt.reset_link = alive_r;
    end else if (iw.req_type <= REQ_OTHER) begin
      case (phase_r)
        PH_REBOOT: begin
          out_nxt.send_reboot = 1'b1;
        end
        PH_VERSION: begin
          if (iw.req_type == REQ_VERSION) begin
            out_nxt.send_params = 1'b1;
          end else begin
            out_nxt.send_version_request = (retry_r == 8'd0);
          end
        end
        PH_SCAN: begin
          if (iw.req_type == REQ_DATA) begin
            out_nxt.drop_data = iw.queue_full;
            out_nxt.push_data = !iw.queue_full;
          end
          if (req_window_r > credit_dec) begin
            out_nxt.data_requests = req_window_r - credit_dec;
          end
        end
        default: begin
        end
      endcase
    end
    out_nxt.phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_REBOOT;
      credit_r    <= 4'd0;
      retry_r     <= 8'd0;
      alive_r     <= 1'b0;
      flags_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r  <= phase_nxt;
        credit_r <= credit_nxt;
        retry_r  <= retry_nxt;
        alive_r  <= alive_nxt;
        flags_r  <= flags_nxt;
      end
      if (in_ch.ready) begin
        out_valid_r <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  a_timeout_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && iw.req_type == REQ_TIMEOUT && alive_r |=>
      out_valid_r && out_r.reset_link && out_r.phase == PH_REBOOT && !alive_r && credit_r == 4'd0)
    else $error("timeout with live head did not reset the sequence");

  a_push_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.push_data && out_r.drop_data))
    else $error("head data both pushed and dropped");

  a_reqs_scan_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.data_requests != 4'd0 |-> out_r.phase == PH_SCAN)
    else $error("data requests issued outside scanning");

  a_phase_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_r.phase == phase_r)
    else $error("reported phase differs from phase register");

endmodule

`default_nettype wire
